// ===== rtl/bdkit_pkg.sv =====
// Shared types and constants of the bucketed djb2 key index table.
`default_nettype none

package bdkit_pkg;

    // Field widths
    localparam int KEY_W    = 32;
    localparam int MODE_W   = 2;
    localparam int IDX_W    = 10;
    localparam int STATUS_W = 2;
    localparam int BKT_OUT_W = 8;

    // Default geometry of the table
    localparam int DEF_BUCKETS          = 256;
    localparam int DEF_SLOTS_PER_BUCKET = 64;

    // Stored indices saturate below this limit
    localparam int INDEX_LIMIT = 1024;

    // djb2 hash
    localparam logic [KEY_W-1:0] DJB2_SEED = 32'd5381;
    localparam int DJB2_SHIFT = 5;
    localparam int BYTE_W     = 8;
    localparam int HASH_STEPS = 4;

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_DROP = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd2;

    // Controller states
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_HASH,
        ST_CLEAR,
        ST_FILL_RD,
        ST_FILL_CHK,
        ST_SCAN
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/bucketed_djb2_key_index_table_unit.sv =====
// Top level: controller of the bucketed djb2 key index table.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------
//  command  | start in, busy out   | i_mode, i_key, i_entry_index
//  result   | o_valid strobe out   | o_status, o_found_index, o_bucket
//
// After reset the fill-count memory is swept, one bucket a cycle, and busy is
// high until the sweep is done and the first command can be taken.
// Every command first runs the hash unit: 4 djb2 rounds and 3 reduction
// steps. An unused mode then ends at once, clear sweeps every bucket's fill
// count like the reset sweep, insert reads the fill count and writes the slot,
// lookup misses on an empty bucket and otherwise reads k = 1..fill slots from
// the slot memory. The slot memory has one read port: one slot per cycle.
// The result strobe lasts one cycle and cannot be stalled; busy drops with it.
`default_nettype none

module bucketed_djb2_key_index_table_unit #(
    parameter int BUCKETS          = bdkit_pkg::DEF_BUCKETS,
    parameter int SLOTS_PER_BUCKET = bdkit_pkg::DEF_SLOTS_PER_BUCKET
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [bdkit_pkg::MODE_W-1:0]      i_mode,
    input  wire logic [bdkit_pkg::KEY_W-1:0]       i_key,
    input  wire logic [bdkit_pkg::IDX_W-1:0]       i_entry_index,
    output logic                                   o_valid,
    output logic      [bdkit_pkg::STATUS_W-1:0]    o_status,
    output logic      [bdkit_pkg::IDX_W-1:0]       o_found_index,
    output logic      [bdkit_pkg::BKT_OUT_W-1:0]   o_bucket
);

    import bdkit_pkg::*;

    localparam int BW    = $clog2(BUCKETS);
    localparam int FW    = $clog2(SLOTS_PER_BUCKET + 1);
    localparam int DEPTH = BUCKETS * SLOTS_PER_BUCKET;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = KEY_W + IDX_W;
    localparam logic [FW-1:0] SLOTS_C = FW'(SLOTS_PER_BUCKET);
    localparam logic [BW-1:0] LAST_BKT = BW'(BUCKETS - 1);

    t_state r_state, n_state;

    // Transaction registers
    logic [MODE_W-1:0]   r_mode;
    logic [KEY_W-1:0]    r_key;
    logic [IDX_W-1:0]    r_idx;
    logic [BW-1:0]       r_bkt, n_bkt;
    logic [AW-1:0]       r_base, n_base;
    logic [AW-1:0]       r_addr, n_addr;
    logic [FW-1:0]       r_cnt, n_cnt;
    logic [FW-1:0]       r_n, n_n;
    logic [BW-1:0]       r_clr, n_clr;

    // Result registers
    logic                r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [IDX_W-1:0]    r_found, n_found;

    // Hash unit and memory ports
    logic                w_hash_start;
    logic                w_hash_done;
    logic [BW-1:0]       w_hash_bkt;
    logic                w_accept;

    logic                w_fill_we;
    logic [BW-1:0]       w_fill_waddr;
    logic [FW-1:0]       w_fill_wdata;
    logic                w_fill_re;
    logic [FW-1:0]       w_fill;

    logic                w_slot_we;
    logic [AW-1:0]       w_slot_waddr;
    logic                w_slot_re;
    logic [AW-1:0]       w_slot_raddr;
    logic [SW-1:0]       w_slot;

    assign w_accept     = start && !busy;
    assign w_hash_start = w_accept;

    bdkit_hash #(
        .BUCKETS (BUCKETS)
    ) u_hash (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_hash_start),
        .i_key    (i_key),
        .o_done   (w_hash_done),
        .o_bucket (w_hash_bkt)
    );

    // Per-bucket fill counts
    bdkit_ram #(
        .DEPTH (BUCKETS),
        .WIDTH (FW)
    ) u_fill_ram (
        .i_clk   (i_clk),
        .i_we    (w_fill_we),
        .i_waddr (w_fill_waddr),
        .i_wdata (w_fill_wdata),
        .i_re    (w_fill_re),
        .i_raddr (r_bkt),
        .o_rdata (w_fill)
    );

    // Key and index of every slot
    bdkit_ram #(
        .DEPTH (DEPTH),
        .WIDTH (SW)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_slot_we),
        .i_waddr (w_slot_waddr),
        .i_wdata ({r_key, r_idx}),
        .i_re    (w_slot_re),
        .i_raddr (w_slot_raddr),
        .o_rdata (w_slot)
    );

    // Command capture, index saturated to the storable range
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode <= i_mode;
            r_key  <= i_key;
            r_idx  <= (32'(i_entry_index) >= INDEX_LIMIT) ? IDX_W'(INDEX_LIMIT - 1)
                                                          : i_entry_index;
        end
    end

    // State register and control counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_bkt    <= n_bkt;
        r_base   <= n_base;
        r_addr   <= n_addr;
        r_cnt    <= n_cnt;
        r_n      <= n_n;
        r_status <= n_status;
        r_found  <= n_found;
    end

    // Next state, memory control and result.
    // Accesses to a bucket are at least a hash time apart, so a fill-count
    // write always lands before the next read of it.
    always_comb begin
        n_state      = r_state;
        n_bkt        = r_bkt;
        n_base       = r_base;
        n_addr       = r_addr;
        n_cnt        = r_cnt;
        n_n          = r_n;
        n_clr        = r_clr;
        n_out_valid  = 1'b0;
        n_status     = r_status;
        n_found      = r_found;
        w_fill_we    = 1'b0;
        w_fill_waddr = r_clr;
        w_fill_wdata = '0;
        w_fill_re    = 1'b0;
        w_slot_we    = 1'b0;
        w_slot_waddr = r_base + AW'(w_fill);
        w_slot_re    = 1'b0;
        w_slot_raddr = r_base;
        busy         = (r_state != ST_IDLE);

        case (r_state)
            ST_INIT: begin
                w_fill_we = 1'b1;
                n_clr     = r_clr + 1'b1;
                if (r_clr == LAST_BKT) begin
                    n_clr   = '0;
                    n_state = ST_IDLE;
                end
            end

            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_HASH;
                end
            end

            ST_HASH: begin
                if (w_hash_done) begin
                    n_bkt    = w_hash_bkt;
                    n_base   = AW'(32'(w_hash_bkt) * SLOTS_PER_BUCKET);
                    n_clr    = '0;
                    n_status = STATUS_OK;
                    n_found  = '0;
                    case (r_mode)
                        MODE_CLEAR: begin
                            n_state = ST_CLEAR;
                        end
                        MODE_INSERT, MODE_LOOKUP: begin
                            n_state = ST_FILL_RD;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                            n_state     = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_CLEAR: begin
                w_fill_we = 1'b1;
                n_clr     = r_clr + 1'b1;
                if (r_clr == LAST_BKT) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end

            ST_FILL_RD: begin
                w_fill_re = 1'b1;
                n_state   = ST_FILL_CHK;
            end

            ST_FILL_CHK: begin
                if (r_mode == MODE_INSERT) begin
                    if (w_fill < SLOTS_C) begin
                        w_slot_we    = 1'b1;
                        w_fill_we    = 1'b1;
                        w_fill_waddr = r_bkt;
                        w_fill_wdata = w_fill + 1'b1;
                    end else begin
                        n_status = STATUS_DROP;
                    end
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end else if (w_fill == '0) begin
                    n_status    = STATUS_MISS;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end else begin
                    // first slot of the bucket
                    w_slot_re    = 1'b1;
                    w_slot_raddr = r_base;
                    n_addr       = r_base;
                    n_cnt        = FW'(1);
                    n_n          = w_fill;
                    n_state      = ST_SCAN;
                end
            end

            ST_SCAN: begin
                if (w_slot[SW-1 -: KEY_W] == r_key) begin
                    n_found     = w_slot[IDX_W-1:0];
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end else if (r_cnt == r_n) begin
                    n_status    = STATUS_MISS;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end else begin
                    w_slot_re    = 1'b1;
                    w_slot_raddr = r_addr + 1'b1;
                    n_addr       = r_addr + 1'b1;
                    n_cnt        = r_cnt + 1'b1;
                end
            end

            default: begin
                n_state = ST_INIT;
            end
        endcase
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_found_index = r_found;
    assign o_bucket      = BKT_OUT_W'(r_bkt);

`ifndef ASSERT_OFF
    // A result is shown only once the controller has gone back to idle
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_state == ST_IDLE))
        else $error("result strobe while controller busy");

    // The strobe lasts a single cycle per transaction
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |=> !r_out_valid)
        else $error("result strobe longer than one cycle");

    // An accepted command makes the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy)
        else $error("accepted command did not raise busy");

    // Slots are only written below the bucket capacity
    a_slot_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_slot_we |-> (w_fill < SLOTS_C))
        else $error("slot write into a full bucket");

    // The scan never runs past the bucket's fill count
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> ((r_cnt <= r_n) && (r_n <= SLOTS_C) && (r_cnt != '0)))
        else $error("slot scan out of range");
`endif

endmodule

`default_nettype wire

// ===== rtl/bdkit_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
`default_nettype none

module bdkit_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/bdkit_hash.sv =====
// Iterative djb2 hash of a key, then a reduction modulo the bucket count by reciprocal multiply.
`default_nettype none

module bdkit_hash #(
    parameter int BUCKETS = bdkit_pkg::DEF_BUCKETS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [bdkit_pkg::KEY_W-1:0]    i_key,
    output logic                                o_done,
    output logic      [$clog2(BUCKETS)-1:0]     o_bucket
);

    import bdkit_pkg::*;

    localparam int BW        = $clog2(BUCKETS);
    localparam int MUL_STEP  = HASH_STEPS;
    localparam int BACK_STEP = HASH_STEPS + 1;
    localparam int LAST_STEP = HASH_STEPS + 2;
    localparam int STEP_W    = $clog2(LAST_STEP + 1);
    localparam int PROD_W    = 2 * KEY_W;
    localparam logic [BW:0]      BUCKETS_C = (BW + 1)'(BUCKETS);
    localparam logic [KEY_W-1:0] BUCKETS_K = KEY_W'(BUCKETS);
    // floor(2^32 / BUCKETS): the estimated quotient is exact or one short
    localparam logic [KEY_W-1:0] RECIP = KEY_W'((64'd1 << KEY_W) / BUCKETS);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [KEY_W-1:0]  r_h;
    logic [KEY_W-1:0]  r_key;
    logic [KEY_W-1:0]  r_q;
    logic [KEY_W-1:0]  r_qb;
    logic [BW-1:0]     r_rem;

    logic [KEY_W-1:0]  w_mix;
    logic [PROD_W-1:0] w_prod;
    logic [KEY_W-1:0]  w_qb;
    logic [KEY_W-1:0]  w_diff;
    logic [BW:0]       w_red;
    logic [BW:0]       w_sub;
    logic              w_hashing;

    // One djb2 round per cycle, then quotient estimate, back-multiply, correct
    always_comb begin
        w_hashing = (r_step < STEP_W'(HASH_STEPS));
        w_mix     = r_h + (r_h << DJB2_SHIFT) + KEY_W'(r_key[BYTE_W-1:0]);
        w_prod    = PROD_W'(r_h) * PROD_W'(RECIP);
        w_qb      = r_q * BUCKETS_K;
        // remainder estimate is below twice the bucket count
        w_diff    = r_h - r_qb;
        w_red     = w_diff[BW:0];
        w_sub     = w_red - BUCKETS_C;
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(LAST_STEP)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_h   <= DJB2_SEED;
            r_key <= i_key;
            r_rem <= '0;
        end else if (r_busy) begin
            if (w_hashing) begin
                r_h   <= w_mix;
                r_key <= r_key >> BYTE_W;
            end else if (r_step == STEP_W'(MUL_STEP)) begin
                r_q   <= w_prod[PROD_W-1 -: KEY_W];
            end else if (r_step == STEP_W'(BACK_STEP)) begin
                r_qb  <= w_qb;
            end else begin
                r_rem <= (w_red >= BUCKETS_C) ? w_sub[BW-1:0] : w_red[BW-1:0];
            end
        end
    end

    assign o_done   = r_done;
    assign o_bucket = r_rem;

endmodule

`default_nettype wire

// ===== tb/bucketed_djb2_key_index_table_unit_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the bucketed djb2 key index table unit.
module bucketed_djb2_key_index_table_unit_tb;
    import bdkit_pkg::*;

    // Mode value with no operation behind it
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam int RAND_PHASES  = 6;
    localparam int PHASE_ITEMS  = 200;
    // Longest correct quiet stretch is the reset sweep or a clear plus a long gap
    localparam int STALL_LIMIT  = 4000;
    // Clear is the slowest command: hashing plus the bucket sweep
    localparam int DRAIN_CYCLES = 320;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [IDX_W-1:0]     found_index;
        logic [BKT_OUT_W-1:0] bucket;
    } t_table_reply;

    // Shadow copy of the table plus the replies still owed by the block
    class t_key_table_tracker;
        int unsigned      fill [DEF_BUCKETS];
        logic [KEY_W-1:0] slot_key [DEF_BUCKETS][DEF_SLOTS_PER_BUCKET];
        logic [IDX_W-1:0] slot_idx [DEF_BUCKETS][DEF_SLOTS_PER_BUCKET];
        t_table_reply     replies [$];
        int errors;
        int n_clear, n_insert, n_drop, n_hit, n_miss, n_unused, deepest_hit;

        function new();
            foreach (fill[b]) fill[b] = 0;
            errors = 0;
            n_clear = 0;
            n_insert = 0;
            n_drop = 0;
            n_hit = 0;
            n_miss = 0;
            n_unused = 0;
            deepest_hit = 0;
        endfunction

        // djb2 over the key bytes, least significant first, then bucket count
        static function int unsigned bucket_of(logic [KEY_W-1:0] key);
            logic [KEY_W-1:0] h;
            h = DJB2_SEED;
            for (int i = 0; i < HASH_STEPS; i++)
                h = (h << DJB2_SHIFT) + h + key[i*BYTE_W +: BYTE_W];
            return h % DEF_BUCKETS;
        endfunction

        function int pending();
            return replies.size();
        endfunction

        // Update the shadow table for an accepted command and queue its reply
        function void log_command(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] key,
                                  logic [IDX_W-1:0] entry_index);
            int unsigned  b;
            int unsigned  stored;
            bit           hit;
            t_table_reply r;
            b = bucket_of(key);
            hit = 1'b0;
            stored = entry_index;
            r.status = STATUS_OK;
            r.found_index = '0;
            r.bucket = b[BKT_OUT_W-1:0];
            case (mode)
                MODE_CLEAR: begin
                    foreach (fill[i]) fill[i] = 0;
                    n_clear++;
                end
                MODE_INSERT: begin
                    n_insert++;
                    if (fill[b] < DEF_SLOTS_PER_BUCKET) begin
                        if (stored >= INDEX_LIMIT) stored = INDEX_LIMIT - 1;
                        slot_key[b][fill[b]] = key;
                        slot_idx[b][fill[b]] = stored[IDX_W-1:0];
                        fill[b]++;
                    end else begin
                        r.status = STATUS_DROP;
                        n_drop++;
                    end
                end
                MODE_LOOKUP: begin
                    // first match in insertion order wins
                    r.status = STATUS_MISS;
                    for (int i = 0; i < fill[b] && !hit; i++) begin
                        if (slot_key[b][i] == key) begin
                            hit = 1'b1;
                            r.status = STATUS_OK;
                            r.found_index = slot_idx[b][i];
                            if (i + 1 > deepest_hit) deepest_hit = i + 1;
                        end
                    end
                    if (hit) n_hit++;
                    else n_miss++;
                end
                default: n_unused++;
            endcase
            replies.push_back(r);
        endfunction

        // Compare one strobed result with the oldest reply owed
        function void match_reply(logic [STATUS_W-1:0] status,
                                  logic [IDX_W-1:0] found_index,
                                  logic [BKT_OUT_W-1:0] bucket);
            t_table_reply e;
            if (replies.size() == 0) begin
                $error("result with no command pending: status %0d found_index %0d bucket %0d",
                       status, found_index, bucket);
                errors++;
                return;
            end
            e = replies.pop_front();
            if (status !== e.status) begin
                $error("status: expected %0d, actual %0d", e.status, status);
                errors++;
            end
            if (found_index !== e.found_index) begin
                $error("found_index: expected %0d, actual %0d", e.found_index, found_index);
                errors++;
            end
            if (bucket !== e.bucket) begin
                $error("bucket: expected %0d, actual %0d", e.bucket, bucket);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic [MODE_W-1:0]    i_mode = MODE_CLEAR;
    logic [KEY_W-1:0]     i_key = '0;
    logic [IDX_W-1:0]     i_entry_index = '0;
    logic                 busy;
    logic                 o_valid;
    logic [STATUS_W-1:0]  o_status;
    logic [IDX_W-1:0]     o_found_index;
    logic [BKT_OUT_W-1:0] o_bucket;

    t_key_table_tracker tracker = new();
    logic [KEY_W-1:0] stored_keys [$];
    int stall_cycles = 0;

    bucketed_djb2_key_index_table_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_mode        (i_mode),
        .i_key         (i_key),
        .i_entry_index (i_entry_index),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_found_index (o_found_index),
        .o_bucket      (o_bucket)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Result monitor: strobes cannot be stalled, check each one as it passes
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1)
            tracker.match_reply(o_status, o_found_index, o_bucket);
    end

    // Watchdog: any accepted transaction on either side restarts the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && busy === 1'b0) || o_valid === 1'b1) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("no transaction for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, tracker.pending());
            $display("bucketed_djb2_key_index_table_unit_tb NOT OK");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Present one command at this edge and hold it until the block takes it
    task automatic issue(input logic [MODE_W-1:0] mode, input logic [KEY_W-1:0] key,
                         input logic [IDX_W-1:0] entry_index);
        i_mode <= mode;
        i_key <= key;
        i_entry_index <= entry_index;
        start <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        tracker.log_command(mode, key, entry_index);
    endtask

    // Sender holds off until every owed result has been seen
    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (tracker.pending() != 0);
    endtask

    // Random gap after a transaction: mostly none or short, a few long or a full drain; none when quiet
    task automatic idle_between(input bit quiet);
        int r;
        int gap;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) gap = 0;
        else if (r < 92) gap = $urandom_range(1, 4);
        else gap = $urandom_range(10, 80);
        if (!quiet && r == 99) begin
            drain();
        end else if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic [KEY_W-1:0] key_in_bucket(int unsigned b);
        logic [KEY_W-1:0] k;
        k = $urandom;
        while (t_key_table_tracker::bucket_of(k) != b) k = $urandom;
        return k;
    endfunction

    function automatic logic [KEY_W-1:0] known_key();
        if (stored_keys.size() == 0) return $urandom;
        return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
    endfunction

    function automatic logic [IDX_W-1:0] rand_index();
        return IDX_W'($urandom_range(0, INDEX_LIMIT - 1));
    endfunction

    // Stimulus: directed corner cases, then phases of mostly well-formed traffic
    initial begin : stimulus
        int unsigned      hot;
        int               r;
        bit               quiet;
        logic [KEY_W-1:0] k;
        logic [KEY_W-1:0] twin;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: empty table, extremes, duplicates, scan past a slot, clear
        issue(MODE_LOOKUP, '0, '1);
        issue(MODE_UNUSED, '1, '1);
        issue(MODE_INSERT, '0, '0);
        issue(MODE_INSERT, '1, '1);
        issue(MODE_LOOKUP, '0, '0);
        issue(MODE_LOOKUP, '1, '0);
        issue(MODE_INSERT, '1, 10'h155);
        issue(MODE_LOOKUP, '1, '0);
        twin = key_in_bucket(t_key_table_tracker::bucket_of('0));
        while (twin == '0) twin = key_in_bucket(t_key_table_tracker::bucket_of('0));
        issue(MODE_LOOKUP, twin, '0);
        issue(MODE_INSERT, twin, 10'h2AA);
        issue(MODE_LOOKUP, twin, '1);
        issue(MODE_INSERT, 32'h8000_0001, 10'h200);
        issue(MODE_LOOKUP, 32'h8000_0001, '0);
        issue(MODE_INSERT, 32'h7FFF_FFFE, 10'h1FF);
        issue(MODE_LOOKUP, 32'h7FFF_FFFE, '0);
        issue(MODE_CLEAR, '1, '1);
        issue(MODE_LOOKUP, '0, '0);
        issue(MODE_LOOKUP, '1, '0);
        issue(MODE_UNUSED, '0, '0);

        // Random part: each phase clears, then loads one hot bucket past full
        for (int p = 0; p < RAND_PHASES; p++) begin
            quiet = (p == 3);
            if (p == 0) hot = 0;
            else if (p == 1) hot = DEF_BUCKETS - 1;
            else hot = $urandom_range(0, DEF_BUCKETS - 1);
            drain();
            issue(MODE_CLEAR, $urandom, rand_index());
            stored_keys.delete();
            for (int n = 1; n < PHASE_ITEMS; n++) begin
                idle_between(quiet);
                r = $urandom_range(0, 99);
                if (r < 2 && tracker.fill[hot] == DEF_SLOTS_PER_BUCKET) begin
                    issue(MODE_CLEAR, $urandom, rand_index());
                    stored_keys.delete();
                end else if (r < 3) begin
                    issue(MODE_UNUSED, $urandom, rand_index());
                end else if (r < 43) begin
                    k = key_in_bucket(hot);
                    issue(MODE_INSERT, k, rand_index());
                    stored_keys.push_back(k);
                end else if (r < 53) begin
                    k = $urandom;
                    issue(MODE_INSERT, k, rand_index());
                    stored_keys.push_back(k);
                end else if (r < 58) begin
                    // duplicate of an earlier key
                    issue(MODE_INSERT, known_key(), rand_index());
                end else if (r < 83) begin
                    issue(MODE_LOOKUP, known_key(), rand_index());
                end else if (r < 93) begin
                    // absent key in the hot bucket: scans every occupied slot
                    issue(MODE_LOOKUP, key_in_bucket(hot), rand_index());
                end else begin
                    issue(MODE_LOOKUP, $urandom, rand_index());
                end
            end
        end

        // Wait out every owed result, then watch for stray strobes
        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("run covered %0d clears, %0d inserts (%0d dropped on a full bucket), %0d unused",
                 tracker.n_clear, tracker.n_insert, tracker.n_drop, tracker.n_unused);
        $display("and %0d lookups: %0d hits, %0d misses, deepest hit at slot %0d of %0d",
                 tracker.n_hit + tracker.n_miss, tracker.n_hit, tracker.n_miss,
                 tracker.deepest_hit, DEF_SLOTS_PER_BUCKET);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("bucketed_djb2_key_index_table_unit_tb OK");
        end else begin
            $display("bucketed_djb2_key_index_table_unit_tb NOT OK");
        end
        $finish;
    end

endmodule
